[src/dsf_pkg.sv]
// ----------------------------------------------------------------------------
// dsf_pkg
// Shared widths, constants and item types for the damped spring force unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dsf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int POS_W   = 32;   // positions and velocities
    localparam int LEN_W   = 31;   // rest length
    localparam int GAIN_W  = 32;   // stiffness and damping
    localparam int PIN_W   = 2;
    localparam int FORCE_W = 48;

    localparam int DIFF_W  = POS_W + 1;     // exact difference of two positions
    localparam int MAG_W   = POS_W;         // magnitude of such a difference
    localparam int DIST_W  = 33;            // floor(sqrt(dx^2 + dy^2))
    localparam int RAD_W   = 2 * DIST_W;    // squared distance / dot magnitude
    localparam int QD_W    = 34;            // dot / distance quotient

    localparam int PIN_FIRST  = 0;
    localparam int PIN_SECOND = 1;

    localparam logic signed [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic signed [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

    typedef struct packed {
        logic signed [POS_W-1:0] first_pos_x;
        logic signed [POS_W-1:0] first_pos_y;
        logic signed [POS_W-1:0] second_pos_x;
        logic signed [POS_W-1:0] second_pos_y;
        logic signed [POS_W-1:0] first_vel_x;
        logic signed [POS_W-1:0] first_vel_y;
        logic signed [POS_W-1:0] second_vel_x;
        logic signed [POS_W-1:0] second_vel_y;
        logic [LEN_W-1:0]        rest_length;
        logic [GAIN_W-1:0]       stiffness;
        logic [GAIN_W-1:0]       damping;
        logic [PIN_W-1:0]        pin_flags;
    } t_in_item;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_first_x;
        logic signed [FORCE_W-1:0] force_first_y;
        logic signed [FORCE_W-1:0] force_second_x;
        logic signed [FORCE_W-1:0] force_second_y;
        logic                      degenerate;
    } t_out_item;

endpackage

`default_nettype wire

[src/dsf_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// dsf_sqrt_pipe
// Integer square root, one root bit per register stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module dsf_sqrt_pipe #(
    parameter int RW = 33,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_rad,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [RW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    localparam int RMW = RW + 2;

    logic [RW-1:0]   r_v;
    logic [2*RW-1:0] r_rad  [RW];
    logic [RMW-1:0]  r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [SW-1:0]   r_side [RW];

    logic [2*RW-1:0] s_rad  [RW];
    logic [RMW-1:0]  s_rem  [RW];
    logic [RW-1:0]   s_root [RW];
    logic [RMW-1:0]  w_t    [RW];
    logic [RMW-1:0]  w_trial[RW];
    logic [2*RW-1:0] n_rad  [RW];
    logic [RMW-1:0]  n_rem  [RW];
    logic [RW-1:0]   n_root [RW];

    always_comb begin
        s_rad[0]  = i_rad;
        s_rem[0]  = '0;
        s_root[0] = '0;
        for (int j = 1; j < RW; j++) begin
            s_rad[j]  = r_rad[j-1];
            s_rem[j]  = r_rem[j-1];
            s_root[j] = r_root[j-1];
        end
        for (int j = 0; j < RW; j++) begin
            // bring down the next pair of radicand bits, try root*4+1
            w_t[j]     = {s_rem[j][RMW-3:0], s_rad[j][2*RW-1 -: 2]};
            w_trial[j] = {s_root[j], 2'b01};
            n_rad[j]   = {s_rad[j][2*RW-3:0], 2'b00};
            if (w_t[j] >= w_trial[j]) begin
                n_rem[j]  = w_t[j] - w_trial[j];
                n_root[j] = {s_root[j][RW-2:0], 1'b1};
            end else begin
                n_rem[j]  = w_t[j];
                n_root[j] = {s_root[j][RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[RW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int j = 0; j < RW; j++) begin
                r_rad[j]  <= n_rad[j];
                r_rem[j]  <= n_rem[j];
                r_root[j] <= n_root[j];
            end
            for (int j = 1; j < RW; j++) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

`default_nettype wire

[src/dsf_div_pipe.sv]
// ----------------------------------------------------------------------------
// dsf_div_pipe
// Restoring unsigned divider, one quotient bit per register stage.
// The quotient must fit in QW bits (dividend below divisor * 2^QW).
// ----------------------------------------------------------------------------
`default_nettype none

module dsf_div_pipe #(
    parameter int NW = 66,
    parameter int DW = 33,
    parameter int QW = 34,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [DW-1:0] o_den,
    output logic [SW-1:0] o_side
);

    logic [QW-1:0] r_v;
    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_lq   [QW];   // dividend bits still to come, quotient bits shifted in
    logic [DW-1:0] r_den  [QW];
    logic [SW-1:0] r_side [QW];

    logic [DW-1:0] s_rem  [QW];
    logic [QW-1:0] s_lq   [QW];
    logic [DW-1:0] s_den  [QW];
    logic [DW:0]   w_t    [QW];
    logic [DW:0]   w_d    [QW];
    logic          w_ge   [QW];
    logic [DW:0]   w_diff [QW];
    logic [DW-1:0] n_rem  [QW];
    logic [QW-1:0] n_lq   [QW];

    always_comb begin
        s_rem[0] = DW'(i_num >> QW);
        s_lq[0]  = i_num[QW-1:0];
        s_den[0] = i_den;
        for (int j = 1; j < QW; j++) begin
            s_rem[j] = r_rem[j-1];
            s_lq[j]  = r_lq[j-1];
            s_den[j] = r_den[j-1];
        end
        for (int j = 0; j < QW; j++) begin
            w_t[j]    = {s_rem[j], s_lq[j][QW-1]};
            w_d[j]    = {1'b0, s_den[j]};
            w_ge[j]   = (w_t[j] >= w_d[j]);
            w_diff[j] = w_ge[j] ? (w_t[j] - w_d[j]) : w_t[j];
            n_rem[j]  = w_diff[j][DW-1:0];
            n_lq[j]   = {s_lq[j][QW-2:0], w_ge[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int j = 0; j < QW; j++) begin
                r_rem[j] <= n_rem[j];
                r_lq[j]  <= n_lq[j];
                r_den[j] <= s_den[j];
            end
            for (int j = 1; j < QW; j++) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_lq[QW-1];
    assign o_den   = r_den[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

`default_nettype wire

[src/dsf_out_buf.sv]
// ----------------------------------------------------------------------------
// dsf_out_buf
// Output register plus skid entry; stalls the pipeline only when both hold.
// ----------------------------------------------------------------------------
`default_nettype none

module dsf_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  dsf_pkg::t_out_item  i_item,
    output logic                o_adv,
    output logic                o_valid,
    input  logic                i_ready,
    output dsf_pkg::t_out_item  o_item
);

    logic               r_out_v;
    logic               r_skid_v;
    dsf_pkg::t_out_item r_out;
    dsf_pkg::t_out_item r_skid;
    logic               w_push;
    logic               w_pop;

    assign o_adv  = !r_skid_v;
    assign w_push = o_adv && i_valid;
    assign w_pop  = r_out_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_push) begin
            if (r_out_v && !w_pop) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (r_out_v && !w_pop) begin
                r_skid <= i_item;
            end else begin
                r_out <= i_item;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;

endmodule

`default_nettype wire

[src/damped_spring_force_unit.sv]
// ----------------------------------------------------------------------------
// damped_spring_force_unit
// 2D damped spring force, one spring item per cycle while not stalled, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  spring  | i_valid / o_ready   | i_item: positions, velocities, L, k, c, pins
//  force   | o_valid / i_ready   | o_item: four saturated forces, degenerate
//
//  Throughput: one item per cycle unless the skid entry is full. The pipeline holds the
//  33-stage square root, the 34-stage dot divider and the (67 - FRAC_BITS)-stage
//  force divider, plus the arithmetic stages.
//  Reset clears only valid bits; payload registers are left as they are.
//  A full skid entry freezes every stage at once, so nothing is lost or repeated;
//  the output register and skid entry let one stalled result wait while the
//  pipeline keeps taking items.
// ----------------------------------------------------------------------------
`default_nettype none

module damped_spring_force_unit #(
    parameter int FRAC_BITS = dsf_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  dsf_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output dsf_pkg::t_out_item o_item
);

    localparam int MAG_W  = dsf_pkg::MAG_W;
    localparam int DIFF_W = dsf_pkg::DIFF_W;
    localparam int DIST_W = dsf_pkg::DIST_W;
    localparam int RAD_W  = dsf_pkg::RAD_W;
    localparam int QD_W   = dsf_pkg::QD_W;
    localparam int GAIN_W = dsf_pkg::GAIN_W;
    localparam int LEN_W  = dsf_pkg::LEN_W;
    localparam int PIN_W  = dsf_pkg::PIN_W;
    localparam int FW     = dsf_pkg::FORCE_W;

    localparam int SQ_W   = 2 * MAG_W;            // one square or product
    localparam int CQ_W   = GAIN_W + QD_W;        // c * q
    localparam int KE_W   = GAIN_W + DIST_W;      // k * |d - L|
    localparam int T_W    = CQ_W - FRAC_BITS;     // each scaled term
    localparam int S_W    = T_W + 2;              // signed sum of two terms
    localparam int CMW    = T_W + 1;              // |coef|
    localparam int HI_W   = CMW - MAG_W;
    localparam int NUM_W  = MAG_W + CMW;
    localparam int VW     = CMW + 1;
    localparam int EW     = (VW > FW + 1) ? VW : FW + 1;

    localparam logic signed [EW-1:0] SAT_HI = EW'(dsf_pkg::FORCE_MAX);
    localparam logic signed [EW-1:0] SAT_LO = EW'(dsf_pkg::FORCE_MIN);

    typedef struct packed {
        logic [RAD_W-1:0]  dm;
        logic              dn;
        logic [MAG_W-1:0]  mdpx;
        logic [MAG_W-1:0]  mdpy;
        logic              sx;
        logic              sy;
        logic [LEN_W-1:0]  len;
        logic [GAIN_W-1:0] k;
        logic [GAIN_W-1:0] c;
        logic [PIN_W-1:0]  pins;
    } t_sq_side;

    typedef struct packed {
        logic              dn;
        logic [MAG_W-1:0]  mdpx;
        logic [MAG_W-1:0]  mdpy;
        logic              sx;
        logic              sy;
        logic [LEN_W-1:0]  len;
        logic [GAIN_W-1:0] k;
        logic [GAIN_W-1:0] c;
        logic [PIN_W-1:0]  pins;
    } t_qd_side;

    typedef struct packed {
        logic             negx;
        logic             negy;
        logic             deg;
        logic [PIN_W-1:0] pins;
    } t_fd_side;

    function automatic logic signed [FW-1:0] f_sat(input logic signed [EW-1:0] x);
        logic signed [FW-1:0] res;
        if (x > SAT_HI) begin
            res = dsf_pkg::FORCE_MAX;
        end else if (x < SAT_LO) begin
            res = dsf_pkg::FORCE_MIN;
        end else begin
            res = x[FW-1:0];
        end
        return res;
    endfunction

    logic w_adv;
    assign o_ready = w_adv;

    // ---------------- stage 0: exact differences ----------------
    logic              r0_v;
    logic [DIFF_W-1:0] r0_dpx, r0_dpy, r0_dvx, r0_dvy;
    logic [LEN_W-1:0]  r0_len;
    logic [GAIN_W-1:0] r0_k, r0_c;
    logic [PIN_W-1:0]  r0_pins;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_dpx  <= {i_item.first_pos_x[MAG_W-1], i_item.first_pos_x}
                     - {i_item.second_pos_x[MAG_W-1], i_item.second_pos_x};
            r0_dpy  <= {i_item.first_pos_y[MAG_W-1], i_item.first_pos_y}
                     - {i_item.second_pos_y[MAG_W-1], i_item.second_pos_y};
            r0_dvx  <= {i_item.first_vel_x[MAG_W-1], i_item.first_vel_x}
                     - {i_item.second_vel_x[MAG_W-1], i_item.second_vel_x};
            r0_dvy  <= {i_item.first_vel_y[MAG_W-1], i_item.first_vel_y}
                     - {i_item.second_vel_y[MAG_W-1], i_item.second_vel_y};
            r0_len  <= i_item.rest_length;
            r0_k    <= i_item.stiffness;
            r0_c    <= i_item.damping;
            r0_pins <= i_item.pin_flags;
        end
    end

    // ---------------- stage 1: magnitudes and signs ----------------
    logic              r1_v;
    logic [MAG_W-1:0]  r1_mdpx, r1_mdpy, r1_mdvx, r1_mdvy;
    logic              r1_sx, r1_sy, r1_nx, r1_ny;
    logic [LEN_W-1:0]  r1_len;
    logic [GAIN_W-1:0] r1_k, r1_c;
    logic [PIN_W-1:0]  r1_pins;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_mdpx <= MAG_W'(r0_dpx[DIFF_W-1] ? -r0_dpx : r0_dpx);
            r1_mdpy <= MAG_W'(r0_dpy[DIFF_W-1] ? -r0_dpy : r0_dpy);
            r1_mdvx <= MAG_W'(r0_dvx[DIFF_W-1] ? -r0_dvx : r0_dvx);
            r1_mdvy <= MAG_W'(r0_dvy[DIFF_W-1] ? -r0_dvy : r0_dvy);
            r1_sx   <= r0_dpx[DIFF_W-1];
            r1_sy   <= r0_dpy[DIFF_W-1];
            r1_nx   <= r0_dpx[DIFF_W-1] ^ r0_dvx[DIFF_W-1];
            r1_ny   <= r0_dpy[DIFF_W-1] ^ r0_dvy[DIFF_W-1];
            r1_len  <= r0_len;
            r1_k    <= r0_k;
            r1_c    <= r0_c;
            r1_pins <= r0_pins;
        end
    end

    // ---------------- stage 2: squares and dot products ----------------
    logic              r2_v;
    logic [SQ_W-1:0]   r2_sqx, r2_sqy, r2_px, r2_py;
    logic [MAG_W-1:0]  r2_mdpx, r2_mdpy;
    logic              r2_sx, r2_sy, r2_nx, r2_ny;
    logic [LEN_W-1:0]  r2_len;
    logic [GAIN_W-1:0] r2_k, r2_c;
    logic [PIN_W-1:0]  r2_pins;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_sqx  <= r1_mdpx * r1_mdpx;
            r2_sqy  <= r1_mdpy * r1_mdpy;
            r2_px   <= r1_mdvx * r1_mdpx;
            r2_py   <= r1_mdvy * r1_mdpy;
            r2_mdpx <= r1_mdpx;
            r2_mdpy <= r1_mdpy;
            r2_sx   <= r1_sx;
            r2_sy   <= r1_sy;
            r2_nx   <= r1_nx;
            r2_ny   <= r1_ny;
            r2_len  <= r1_len;
            r2_k    <= r1_k;
            r2_c    <= r1_c;
            r2_pins <= r1_pins;
        end
    end

    // ---------------- stage 3: squared distance, signed dot ----------------
    logic             r3_v;
    logic [RAD_W-1:0] r3_rad;
    t_sq_side         r3_side;
    logic [RAD_W-1:0] n3_dm;
    logic             n3_dn;

    always_comb begin
        if (r2_nx == r2_ny) begin
            n3_dm = RAD_W'(r2_px) + RAD_W'(r2_py);
            n3_dn = r2_nx;
        end else if (r2_px >= r2_py) begin
            n3_dm = RAD_W'(r2_px - r2_py);
            n3_dn = r2_nx;
        end else begin
            n3_dm = RAD_W'(r2_py - r2_px);
            n3_dn = r2_ny;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_rad       <= RAD_W'(r2_sqx) + RAD_W'(r2_sqy);
            r3_side.dm   <= n3_dm;
            r3_side.dn   <= n3_dn;
            r3_side.mdpx <= r2_mdpx;
            r3_side.mdpy <= r2_mdpy;
            r3_side.sx   <= r2_sx;
            r3_side.sy   <= r2_sy;
            r3_side.len  <= r2_len;
            r3_side.k    <= r2_k;
            r3_side.c    <= r2_c;
            r3_side.pins <= r2_pins;
        end
    end

    // ---------------- distance ----------------
    logic                       w_sq_v;
    logic [DIST_W-1:0]          w_dist;
    logic [$bits(t_sq_side)-1:0] w_sq_side_raw;
    t_sq_side                   w_sq_side;
    t_qd_side                   w_qd_side_in;

    dsf_sqrt_pipe #(
        .RW (DIST_W),
        .SW ($bits(t_sq_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r3_v),
        .i_rad   (r3_rad),
        .i_side  (r3_side),
        .o_valid (w_sq_v),
        .o_root  (w_dist),
        .o_side  (w_sq_side_raw)
    );

    assign w_sq_side = t_sq_side'(w_sq_side_raw);

    always_comb begin
        w_qd_side_in.dn   = w_sq_side.dn;
        w_qd_side_in.mdpx = w_sq_side.mdpx;
        w_qd_side_in.mdpy = w_sq_side.mdpy;
        w_qd_side_in.sx   = w_sq_side.sx;
        w_qd_side_in.sy   = w_sq_side.sy;
        w_qd_side_in.len  = w_sq_side.len;
        w_qd_side_in.k    = w_sq_side.k;
        w_qd_side_in.c    = w_sq_side.c;
        w_qd_side_in.pins = w_sq_side.pins;
    end

    // ---------------- q = dot / d ----------------
    logic                        w_qd_v;
    logic [QD_W-1:0]             w_q;
    logic [DIST_W-1:0]           w_qd_dist;
    logic [$bits(t_qd_side)-1:0] w_qd_side_raw;
    t_qd_side                    w_qd_side;

    dsf_div_pipe #(
        .NW (RAD_W),
        .DW (DIST_W),
        .QW (QD_W),
        .SW ($bits(t_qd_side))
    ) u_div_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_sq_v),
        .i_num   (w_sq_side.dm),
        .i_den   (w_dist),
        .i_side  (w_qd_side_in),
        .o_valid (w_qd_v),
        .o_quo   (w_q),
        .o_den   (w_qd_dist),
        .o_side  (w_qd_side_raw)
    );

    assign w_qd_side = t_qd_side'(w_qd_side_raw);

    // ---------------- stage 4: c*q, spring extension ----------------
    logic              r4_v;
    logic [CQ_W-1:0]   r4_cq;
    logic [DIST_W:0]   r4_e;
    logic              r4_deg, r4_dn, r4_sx, r4_sy;
    logic [MAG_W-1:0]  r4_mdpx, r4_mdpy;
    logic [DIST_W-1:0] r4_d;
    logic [GAIN_W-1:0] r4_k;
    logic [PIN_W-1:0]  r4_pins;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_cq   <= w_qd_side.c * w_q;
            r4_e    <= {1'b0, w_qd_dist} - (DIST_W+1)'(w_qd_side.len);
            r4_deg  <= (w_qd_dist == '0);
            r4_dn   <= w_qd_side.dn;
            r4_sx   <= w_qd_side.sx;
            r4_sy   <= w_qd_side.sy;
            r4_mdpx <= w_qd_side.mdpx;
            r4_mdpy <= w_qd_side.mdpy;
            r4_d    <= w_qd_dist;
            r4_k    <= w_qd_side.k;
            r4_pins <= w_qd_side.pins;
        end
    end

    // ---------------- stage 5: |e|, scaled damping term ----------------
    logic              r5_v;
    logic [DIST_W-1:0] r5_me;
    logic              r5_es;
    logic [T_W-1:0]    r5_dmg;
    logic              r5_deg, r5_dn, r5_sx, r5_sy;
    logic [MAG_W-1:0]  r5_mdpx, r5_mdpy;
    logic [DIST_W-1:0] r5_d;
    logic [GAIN_W-1:0] r5_k;
    logic [PIN_W-1:0]  r5_pins;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_me   <= DIST_W'(r4_e[DIST_W] ? -r4_e : r4_e);
            r5_es   <= r4_e[DIST_W];
            r5_dmg  <= T_W'(r4_cq >> FRAC_BITS);
            r5_deg  <= r4_deg;
            r5_dn   <= r4_dn;
            r5_sx   <= r4_sx;
            r5_sy   <= r4_sy;
            r5_mdpx <= r4_mdpx;
            r5_mdpy <= r4_mdpy;
            r5_d    <= r4_d;
            r5_k    <= r4_k;
            r5_pins <= r4_pins;
        end
    end

    // ---------------- stage 6: k*|e| ----------------
    logic              r6_v;
    logic [KE_W-1:0]   r6_ke;
    logic              r6_es;
    logic [T_W-1:0]    r6_dmg;
    logic              r6_deg, r6_dn, r6_sx, r6_sy;
    logic [MAG_W-1:0]  r6_mdpx, r6_mdpy;
    logic [DIST_W-1:0] r6_d;
    logic [PIN_W-1:0]  r6_pins;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_ke   <= r5_k * r5_me;
            r6_es   <= r5_es;
            r6_dmg  <= r5_dmg;
            r6_deg  <= r5_deg;
            r6_dn   <= r5_dn;
            r6_sx   <= r5_sx;
            r6_sy   <= r5_sy;
            r6_mdpx <= r5_mdpx;
            r6_mdpy <= r5_mdpy;
            r6_d    <= r5_d;
            r6_pins <= r5_pins;
        end
    end

    // ---------------- stage 7: signed sum of spring and damping terms ----------
    logic              r7_v;
    logic [S_W-1:0]    r7_s;
    logic              r7_deg, r7_sx, r7_sy;
    logic [MAG_W-1:0]  r7_mdpx, r7_mdpy;
    logic [DIST_W-1:0] r7_d;
    logic [PIN_W-1:0]  r7_pins;
    logic [S_W-1:0]    w7_spr, w7_dmp;

    always_comb begin
        w7_spr = S_W'(T_W'(r6_ke >> FRAC_BITS));
        w7_dmp = S_W'(r6_dmg);
        if (r6_es) begin
            w7_spr = -w7_spr;
        end
        if (r6_dn) begin
            w7_dmp = -w7_dmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_s    <= w7_spr + w7_dmp;
            r7_deg  <= r6_deg;
            r7_sx   <= r6_sx;
            r7_sy   <= r6_sy;
            r7_mdpx <= r6_mdpx;
            r7_mdpy <= r6_mdpy;
            r7_d    <= r6_d;
            r7_pins <= r6_pins;
        end
    end

    // ---------------- stage 8: coef = -sum as magnitude and sign ---------------
    logic              r8_v;
    logic [CMW-1:0]    r8_cm;
    logic              r8_negx, r8_negy;
    logic              r8_deg;
    logic [MAG_W-1:0]  r8_mdpx, r8_mdpy;
    logic [DIST_W-1:0] r8_d;
    logic [PIN_W-1:0]  r8_pins;
    logic              w8_cneg;

    // coef is negative exactly when the sum is positive
    assign w8_cneg = !r7_s[S_W-1] && (r7_s != '0);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_cm   <= CMW'(r7_s[S_W-1] ? -r7_s : r7_s);
            r8_negx <= r7_sx ^ w8_cneg;
            r8_negy <= r7_sy ^ w8_cneg;
            r8_deg  <= r7_deg;
            r8_mdpx <= r7_mdpx;
            r8_mdpy <= r7_mdpy;
            r8_d    <= r7_d;
            r8_pins <= r7_pins;
        end
    end

    // ---------------- stage 9: partial products |dp| * |coef| ----------------
    logic              r9_v;
    logic [SQ_W-1:0]   r9_pxl, r9_pyl;
    logic [CMW-1:0]    r9_pxh, r9_pyh;
    t_fd_side          r9_side;
    logic [DIST_W-1:0] r9_d;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r9_pxl       <= r8_mdpx * r8_cm[MAG_W-1:0];
            r9_pyl       <= r8_mdpy * r8_cm[MAG_W-1:0];
            r9_pxh       <= r8_mdpx * r8_cm[CMW-1 -: HI_W];
            r9_pyh       <= r8_mdpy * r8_cm[CMW-1 -: HI_W];
            r9_side.negx <= r8_negx;
            r9_side.negy <= r8_negy;
            r9_side.deg  <= r8_deg;
            r9_side.pins <= r8_pins;
            r9_d         <= r8_d;
        end
    end

    // ---------------- stage 10: combine partial products ----------------
    logic              r10_v;
    logic [NUM_W-1:0]  r10_nx, r10_ny;
    t_fd_side          r10_side;
    logic [DIST_W-1:0] r10_d;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r10_nx   <= NUM_W'(r9_pxl) + {r9_pxh, {MAG_W{1'b0}}};
            r10_ny   <= NUM_W'(r9_pyl) + {r9_pyh, {MAG_W{1'b0}}};
            r10_side <= r9_side;
            r10_d    <= r9_d;
        end
    end

    // ---------------- force magnitudes: num / d per axis ----------------
    logic                        w_fd_v;
    logic [CMW-1:0]              w_mx, w_my;
    logic [$bits(t_fd_side)-1:0] w_fd_side_raw;
    t_fd_side                    w_fd_side;

    dsf_div_pipe #(
        .NW (NUM_W),
        .DW (DIST_W),
        .QW (CMW),
        .SW ($bits(t_fd_side))
    ) u_div_fx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r10_v),
        .i_num   (r10_nx),
        .i_den   (r10_d),
        .i_side  (r10_side),
        .o_valid (w_fd_v),
        .o_quo   (w_mx),
        .o_den   (),
        .o_side  (w_fd_side_raw)
    );

    dsf_div_pipe #(
        .NW (NUM_W),
        .DW (DIST_W),
        .QW (CMW),
        .SW (1)
    ) u_div_fy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r10_v),
        .i_num   (r10_ny),
        .i_den   (r10_d),
        .i_side  (1'b0),
        .o_valid (),
        .o_quo   (w_my),
        .o_den   (),
        .o_side  ()
    );

    assign w_fd_side = t_fd_side'(w_fd_side_raw);

    // ---------------- stage 11: sign, saturate, pin and degenerate masks -------
    logic               r11_v;
    dsf_pkg::t_out_item r11_item;
    logic signed [VW-1:0] w11_vx, w11_vy;
    logic signed [EW-1:0] w11_ex, w11_ey;
    logic                 w11_zf, w11_zs;

    always_comb begin
        w11_vx = $signed({1'b0, w_mx});
        w11_vy = $signed({1'b0, w_my});
        if (w_fd_side.negx) begin
            w11_vx = -w11_vx;
        end
        if (w_fd_side.negy) begin
            w11_vy = -w11_vy;
        end
        w11_ex = EW'(w11_vx);
        w11_ey = EW'(w11_vy);
        w11_zf = w_fd_side.deg || w_fd_side.pins[dsf_pkg::PIN_FIRST];
        w11_zs = w_fd_side.deg || w_fd_side.pins[dsf_pkg::PIN_SECOND];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r11_item.force_first_x  <= w11_zf ? '0 : f_sat(w11_ex);
            r11_item.force_first_y  <= w11_zf ? '0 : f_sat(w11_ey);
            r11_item.force_second_x <= w11_zs ? '0 : f_sat(-w11_ex);
            r11_item.force_second_y <= w11_zs ? '0 : f_sat(-w11_ey);
            r11_item.degenerate     <= w_fd_side.deg;
        end
    end

    // ---------------- valid bits of the local stages ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v  <= 1'b0;
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
        end else if (w_adv) begin
            r0_v  <= i_valid;
            r1_v  <= r0_v;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= w_qd_v;
            r5_v  <= r4_v;
            r6_v  <= r5_v;
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
            r11_v <= w_fd_v;
        end
    end

    // ---------------- output register and skid ----------------
    dsf_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r11_v),
        .i_item  (r11_item),
        .o_adv   (w_adv),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

[bench/tb_damped_spring_force_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_damped_spring_force_unit
// Self-checking bench: directed spring items from a table, then random items
// with random idling on both channels; every force item is compared with an
// in-bench fixed point model of the damped spring force.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_damped_spring_force_unit;

    localparam int FB         = 16;
    localparam int LATENCY    = 147 - FB;
    localparam int N_RANDOM   = 1630;
    localparam int LONG_STALL = 400;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    dsf_pkg::t_in_item  i_item;
    logic               o_valid;
    logic               i_ready;
    dsf_pkg::t_out_item o_item;

    damped_spring_force_unit #(.FRAC_BITS(FB)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_item (i_item),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_item (o_item)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Forces still owed by the block, oldest first.
    dsf_pkg::t_out_item pending_forces[$];
    int        n_errors;
    bit        gaps_on;         // random idling allowed
    bit        rx_hold;         // request for one long receiver stall
    bit        stim_done;

    // ------------------------------------------------------------------
    // Fixed point model of one spring
    // ------------------------------------------------------------------
    function automatic logic signed [dsf_pkg::FORCE_W-1:0] sat_force(logic signed [127:0] v);
        if (v > 128'sd140737488355327) return dsf_pkg::FORCE_MAX;
        if (v < -128'sd140737488355328) return dsf_pkg::FORCE_MIN;
        return v[dsf_pkg::FORCE_W-1:0];
    endfunction

    function automatic logic [63:0] isqrt(logic [127:0] a);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 34; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= a) r = c;
        end
        return r;
    endfunction

    function automatic dsf_pkg::t_out_item spring_force(dsf_pkg::t_in_item s);
        dsf_pkg::t_out_item  f;
        logic signed [127:0] dpx, dpy, dvx, dvy, dot, q, dmp, e, spr, coef, v;
        logic signed [127:0] dps[2];
        logic signed [127:0] mq, me;
        logic [127:0]        d;
        f = '0;
        dpx = 128'(s.first_pos_x) - 128'(s.second_pos_x);
        dpy = 128'(s.first_pos_y) - 128'(s.second_pos_y);
        dvx = 128'(s.first_vel_x) - 128'(s.second_vel_x);
        dvy = 128'(s.first_vel_y) - 128'(s.second_vel_y);
        d = {64'd0, isqrt(dpx * dpx + dpy * dpy)};
        f.degenerate = (d == 0);
        if (d != 0) begin
            dot = dvx * dpx + dvy * dpy;
            q   = dot / $signed(d);              // truncates toward zero
            mq  = q < 0 ? -q : q;
            dmp = ($signed({96'd0, s.damping}) * mq) >>> FB;
            if (q < 0) dmp = -dmp;
            e   = $signed(d) - $signed({97'd0, s.rest_length});
            me  = e < 0 ? -e : e;
            spr = ($signed({96'd0, s.stiffness}) * me) >>> FB;
            if (e < 0) spr = -spr;
            coef = -(spr + dmp);
            dps[0] = dpx;
            dps[1] = dpy;
            for (int i = 0; i < 2; i++) begin
                v = (dps[i] * coef) / $signed(d);
                if (!s.pin_flags[dsf_pkg::PIN_FIRST]) begin
                    if (i == 0) f.force_first_x = sat_force(v);
                    else        f.force_first_y = sat_force(v);
                end
                if (!s.pin_flags[dsf_pkg::PIN_SECOND]) begin
                    if (i == 0) f.force_second_x = sat_force(-v);
                    else        f.force_second_y = sat_force(-v);
                end
            end
        end
        return f;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // Directed table: expected force typed in only where obvious
    // ------------------------------------------------------------------
    typedef struct {
        dsf_pkg::t_in_item  item;
        bit                 has_want;
        dsf_pkg::t_out_item want;
    } t_row;

    t_row dir_rows[$];

    function automatic dsf_pkg::t_in_item spring(int px1, int py1, int px2, int py2,
                                                 int vx1, int vy1, int vx2, int vy2,
                                                 logic [30:0] len, logic [31:0] k,
                                                 logic [31:0] c, logic [1:0] pins);
        dsf_pkg::t_in_item s;
        s.first_pos_x  = px1;  s.first_pos_y  = py1;
        s.second_pos_x = px2;  s.second_pos_y = py2;
        s.first_vel_x  = vx1;  s.first_vel_y  = vy1;
        s.second_vel_x = vx2;  s.second_vel_y = vy2;
        s.rest_length = len;  s.stiffness = k;  s.damping = c;  s.pin_flags = pins;
        return s;
    endfunction

    task automatic add_row(dsf_pkg::t_in_item s, bit has_want, dsf_pkg::t_out_item want);
        t_row r;
        r.item = s;  r.has_want = has_want;  r.want = want;
        dir_rows.push_back(r);
    endtask

    task automatic build_table();
        dsf_pkg::t_out_item zero_deg;
        dsf_pkg::t_out_item none;
        zero_deg = '0;  zero_deg.degenerate = 1'b1;
        none = '0;
        // coincident points, no pins and both pinned: zero forces, degenerate
        add_row(spring(0, 0, 0, 0, 5, 6, 7, 8, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b00),
                1, zero_deg);
        add_row(spring(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       -1, -1, 1, 1, 31'h7FFF_FFFF, 1, 1, 2'b11), 1, zero_deg);
        // both pinned, distinct points: all zero, not degenerate
        add_row(spring(65536, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 2'b11), 1, none);
        // at rest length, no damping: zero forces
        add_row(spring(65536 * 3, 65536 * 4, 0, 0, 0, 0, 0, 0, 65536 * 5, 65536, 0, 2'b00),
                1, none);
        // stretched: free, first pinned, second pinned
        add_row(spring(65536 * 2, 0, 0, 0, 0, 0, 0, 0, 65536, 65536, 0, 2'b00), 0, none);
        add_row(spring(65536 * 2, 0, 0, 0, 0, 0, 0, 0, 65536, 65536, 0, 2'b01), 0, none);
        add_row(spring(65536 * 2, 0, 0, 0, 0, 0, 0, 0, 65536, 65536, 0, 2'b10), 0, none);
        // compressed with damping and approaching; stretched, damping only, receding
        add_row(spring(0, 65536, 0, 0, 0, -65536, 0, 0, 65536 * 3, 65536 * 2, 65536, 2'b00),
                0, none);
        add_row(spring(0, 65536, 0, 0, 0, 65536, 0, -65536, 0, 0, 65536 * 9, 2'b00), 0, none);
        // extreme positions and velocities: saturation on both sides
        add_row(spring(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                       0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b00), 0, none);
        add_row(spring(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b00), 0, none);
        // one raw unit apart, huge gains
        add_row(spring(1, 0, 0, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0,
                       31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b00), 0, none);
        add_row(spring(0, -1, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 2'b00), 0, none);
        // diagonal, negative offsets, mixed signs
        add_row(spring(-65536 * 7, 65536 * 3, 65536 * 2, -65536 * 9, 12345, -54321,
                       -999, 888, 65536 * 10, 65536 * 40, 65536 / 3, 2'b00), 0, none);
    endtask

    // ------------------------------------------------------------------
    // Random spring: mostly moderate geometry, sometimes extremes
    // ------------------------------------------------------------------
    function automatic logic [31:0] rnd_coord(int sel);
        case (sel)
            0: return $urandom();
            1: return $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $signed($urandom_range(2 * 65536 * 200, 0)) - 65536 * 200;
        endcase
    endfunction

    function automatic dsf_pkg::t_in_item rnd_spring();
        dsf_pkg::t_in_item s;
        int                sel;
        sel = $urandom_range(9, 0) < 2 ? $urandom_range(1, 0) : 2;
        s.first_pos_x  = rnd_coord(sel);
        s.first_pos_y  = rnd_coord(sel);
        s.second_pos_x = rnd_coord(sel);
        s.second_pos_y = rnd_coord(sel);
        if ($urandom_range(19, 0) == 0) begin
            // coincide now and then
            s.second_pos_x = s.first_pos_x;
            s.second_pos_y = s.first_pos_y;
        end
        s.first_vel_x  = rnd_coord(sel);
        s.first_vel_y  = rnd_coord(sel);
        s.second_vel_x = rnd_coord(sel);
        s.second_vel_y = rnd_coord(sel);
        s.rest_length  = $urandom_range(3, 0) == 0 ? 31'($urandom()) :
                         31'($urandom_range(65536 * 300, 0));
        s.stiffness    = $urandom_range(3, 0) == 0 ? $urandom() : $urandom_range(65536 * 50, 0);
        s.damping      = $urandom_range(3, 0) == 0 ? $urandom() : $urandom_range(65536 * 10, 0);
        s.pin_flags    = $urandom_range(3, 0) == 0 ? 2'($urandom_range(3, 1)) : 2'b00;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Sender: present one item, hold until accepted
    // ------------------------------------------------------------------
    task automatic send_spring(dsf_pkg::t_in_item s);
        int gap;
        if (gaps_on && $urandom_range(3, 0) == 0) begin
            gap = $urandom_range(10, 1);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= s;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_forces.push_back(spring_force(s));
    endtask

    initial begin
        dsf_pkg::t_in_item s;
        i_valid   = 1'b0;
        i_item    = '0;
        i_rst_n   = 1'b0;
        gaps_on   = 1'b1;
        rx_hold   = 1'b0;
        stim_done = 1'b0;
        n_errors  = 0;
        build_table();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].has_want && spring_force(dir_rows[r].item) !== dir_rows[r].want)
                report_mismatch("table row model", r, 0);
            send_spring(dir_rows[r].item);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300) begin
                // hold the sender until the block has drained
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_forces.size() != 0) @(posedge i_clk);
            end
            if (n == 500) rx_hold <= 1'b1;    // receiver stalls long; sender keeps going
            if (n == N_RANDOM - 200) gaps_on <= 1'b0;
            s = rnd_spring();
            send_spring(s);
        end
        i_valid   <= 1'b0;
        stim_done <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Receiver: random backpressure, one long stall on request
    // ------------------------------------------------------------------
    initial begin
        int burst;
        i_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold) begin
                i_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
                rx_hold <= 1'b0;
            end else if (gaps_on && $urandom_range(3, 0) == 0) begin
                burst = $urandom_range(10, 1);
                i_ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end else begin
                burst = $urandom_range(20, 1);
                i_ready <= 1'b1;
                repeat (burst) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each accepted force item with the oldest expected one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        dsf_pkg::t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_forces.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
            end else begin
                want = pending_forces.pop_front();
                if (o_item.force_first_x !== want.force_first_x)
                    report_mismatch("force_first_x", 64'(o_item.force_first_x),
                                    64'(want.force_first_x));
                if (o_item.force_first_y !== want.force_first_y)
                    report_mismatch("force_first_y", 64'(o_item.force_first_y),
                                    64'(want.force_first_y));
                if (o_item.force_second_x !== want.force_second_x)
                    report_mismatch("force_second_x", 64'(o_item.force_second_x),
                                    64'(want.force_second_x));
                if (o_item.force_second_y !== want.force_second_y)
                    report_mismatch("force_second_y", 64'(o_item.force_second_y),
                                    64'(want.force_second_y));
                if (o_item.degenerate !== want.degenerate)
                    report_mismatch("degenerate", 64'(o_item.degenerate),
                                    64'(want.degenerate));
            end
        end
    end

    // ------------------------------------------------------------------
    // End of run
    // ------------------------------------------------------------------
    initial begin
        @(posedge i_clk);
        while (!(stim_done && pending_forces.size() == 0)) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_errors == 0 && pending_forces.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
